@@ hdl/wpid_pkg.sv @@
`timescale 1ns / 1ps
// Package for the windowed PID controller: field widths, window size,
// the reciprocal constant for the window average and the register indexes.
// Used by wpid_window and windowed_pid_controller; depends on nothing.
package wpid_pkg;

    localparam int ERR_W     = 24;
    localparam int GAIN_W    = 16;
    localparam int DRIVE_W   = 32;
    localparam int FRAC_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam int WINDOW     = 10;
    localparam int RING_IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int TOTAL_W    = ERR_W + $clog2(WINDOW);
    localparam int DELTA_W    = ERR_W + 1;

    localparam int PROD_W  = GAIN_W + DELTA_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int SHIFT_W = ACC_W - FRAC_W;

    // The magnitude of the running total is divided by WINDOW through a
    // multiplication by a rounded-up reciprocal, which is exact over TOTAL_W bits.
    localparam int DIV_SHIFT = TOTAL_W + $clog2(WINDOW);
    localparam int RECIP_W   = TOTAL_W + 1;
    localparam int QPROD_W   = TOTAL_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP = 2'd0,
        CFG_KI = 2'd1,
        CFG_KD = 2'd2
    } cfg_reg_t;

endpackage

@@ hdl/windowed_pid_controller.sv @@
`timescale 1ns / 1ps
// Windowed PID controller top level. Depends on wpid_pkg and wpid_window.
// Each error word passes through the register stages s1, s2, s3 and the output register to its drive word.
// Throughput is one word per cycle while out_stall is low; the four register stages set by the multipliers and
// the reciprocal divide close up bubbles while the output word waits.
// Reset clears the gains, the error ring, its running total, the previous error
// and all stage valid flags.
module windowed_pid_controller
    import wpid_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [GAIN_W-1:0]           cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [ERR_W-1:0]     error,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [DRIVE_W-1:0]   drive,
    output logic                        saturated
);

    logic signed [GAIN_W-1:0] kp_reg;
    logic signed [GAIN_W-1:0] ki_reg;
    logic signed [GAIN_W-1:0] kd_reg;

    logic take;
    logic signed [TOTAL_W-1:0] total_next;
    logic signed [DELTA_W-1:0] delta_next;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic out_valid_reg;
    logic s1_ready;
    logic s2_ready;
    logic s3_ready;
    logic out_ready;

    logic signed [ERR_W-1:0]   s1_err_reg;
    logic signed [DELTA_W-1:0] s1_delta_reg;
    logic signed [TOTAL_W-1:0] s1_total_reg;

    logic                      s1_neg;
    logic [TOTAL_W-1:0]        s1_mag;
    logic [QPROD_W-1:0]        s1_qprod;
    logic [ERR_W-1:0]          s2_quot_next;
    logic signed [PROD_W-1:0]  s2_pterm_next;
    logic signed [PROD_W-1:0]  s2_dterm_next;

    logic [ERR_W-1:0]          s2_quot_reg;
    logic                      s2_neg_reg;
    logic signed [PROD_W-1:0]  s2_pterm_reg;
    logic signed [PROD_W-1:0]  s2_dterm_reg;

    logic signed [ERR_W:0]     s2_avg;
    logic signed [PROD_W-1:0]  s3_iterm_next;

    logic signed [PROD_W-1:0]  s3_pterm_reg;
    logic signed [PROD_W-1:0]  s3_iterm_reg;
    logic signed [PROD_W-1:0]  s3_dterm_reg;

    logic signed [ACC_W-1:0]   s3_acc;
    logic signed [SHIFT_W-1:0] s3_shifted;
    logic [SHIFT_W-DRIVE_W:0]  s3_top;
    logic signed [DRIVE_W-1:0] drive_next;
    logic                      sat_next;

    logic signed [DRIVE_W-1:0] drive_reg;
    logic                      sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg <= '0;
            ki_reg <= '0;
            kd_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_KP:  kp_reg <= cfg_data;
                CFG_KI:  ki_reg <= cfg_data;
                CFG_KD:  kd_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign out_ready = !out_valid_reg || !out_stall;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_stall  = !s1_ready;
    assign take      = in_valid && s1_ready;

    wpid_window u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .error (error),
        .total (total_next),
        .delta (delta_next)
    );

    always_comb
    begin
        s1_neg        = s1_total_reg[TOTAL_W-1];
        s1_mag        = s1_neg ? TOTAL_W'(-s1_total_reg) : TOTAL_W'(s1_total_reg);
        s1_qprod      = QPROD_W'(s1_mag) * QPROD_W'(RECIP);
        s2_quot_next  = ERR_W'(s1_qprod >> DIV_SHIFT);
        s2_pterm_next = PROD_W'(kp_reg) * PROD_W'(s1_err_reg);
        s2_dterm_next = PROD_W'(kd_reg) * PROD_W'(s1_delta_reg);

        s2_avg        = s2_neg_reg ? -$signed({1'b0, s2_quot_reg})
                                   : $signed({1'b0, s2_quot_reg});
        s3_iterm_next = PROD_W'(ki_reg) * PROD_W'(s2_avg);

        s3_acc     = ACC_W'(s3_pterm_reg) + ACC_W'(s3_iterm_reg) + ACC_W'(s3_dterm_reg);
        s3_shifted = SHIFT_W'(s3_acc >>> FRAC_W);
        s3_top     = s3_shifted[SHIFT_W-1:DRIVE_W-1];
        sat_next   = !((&s3_top) || !(|s3_top));
        if (sat_next)
        begin
            drive_next = s3_shifted[SHIFT_W-1] ? DRIVE_MIN : DRIVE_MAX;
        end
        else
        begin
            drive_next = DRIVE_W'(s3_shifted);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_err_reg   <= error;
            s1_delta_reg <= delta_next;
            s1_total_reg <= total_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_quot_reg  <= s2_quot_next;
            s2_neg_reg   <= s1_neg;
            s2_pterm_reg <= s2_pterm_next;
            s2_dterm_reg <= s2_dterm_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_pterm_reg <= s2_pterm_reg;
            s3_iterm_reg <= s3_iterm_next;
            s3_dterm_reg <= s2_dterm_reg;
        end
        if (out_ready && s3_valid_reg)
        begin
            drive_reg <= drive_next;
            sat_reg   <= sat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign saturated = sat_reg;

    // A clipped word always sits at one of the two range limits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |-> (drive == DRIVE_MAX || drive == DRIVE_MIN))
        else $error("saturated word is not at a range limit");

    // The input is held off only when every stage holds a word.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && out_valid_reg))
        else $error("input stalled with a bubble in the pipeline");

    // An accepted word always lands in the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted word lost at the first stage");

    // A new output word only appears when the last stage held one.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s3_valid_reg))
        else $error("output word appeared without a source");

endmodule

@@ hdl/wpid_window.sv @@
`timescale 1ns / 1ps
// Error window of the PID controller: the ring of recent errors, the running
// total over the ring and the previous error. Depends on wpid_pkg.
module wpid_window
    import wpid_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       take,
    input  logic signed [ERR_W-1:0]    error,
    output logic signed [TOTAL_W-1:0]  total,
    output logic signed [DELTA_W-1:0]  delta
);

    logic signed [ERR_W-1:0]   ring_reg [WINDOW];
    logic [RING_IDX_W-1:0]     pos_reg;
    logic [RING_IDX_W-1:0]     pos_next;
    logic signed [TOTAL_W-1:0] total_reg;
    logic signed [ERR_W-1:0]   prev_reg;

    always_comb
    begin
        total = total_reg - TOTAL_W'(ring_reg[pos_reg]) + TOTAL_W'(error);
        delta = DELTA_W'(error) - DELTA_W'(prev_reg);
        if (pos_reg == RING_IDX_W'(WINDOW - 1))
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                ring_reg[i] <= '0;
            end
            pos_reg   <= '0;
            total_reg <= '0;
            prev_reg  <= '0;
        end
        else if (take)
        begin
            ring_reg[pos_reg] <= error;
            pos_reg           <= pos_next;
            total_reg         <= total;
            prev_reg          <= error;
        end
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for windowed_pid_controller: random and directed error words
// with an in-order predictor of the drive words. Depends on wpid_pkg and the RTL.
module tb_top;
    import wpid_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 5000;
    localparam int PIPE_DEPTH = 4;

    typedef struct {
        logic signed [DRIVE_W-1:0] drive;
        logic                      saturated;
    } drive_word_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [GAIN_W-1:0]         cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic signed [ERR_W-1:0]   error = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [DRIVE_W-1:0] drive;
    logic                      saturated;

    logic signed [ERR_W-1:0] error_q [$];
    drive_word_t             drive_q [$];

    longint gain_p = 0;
    longint gain_i = 0;
    longint gain_d = 0;
    longint last_error = 0;
    longint window_ring [WINDOW] = '{default: 0};
    longint window_total = 0;
    int     window_slot = 0;

    int src_idle_pct = 0;
    int rcv_idle_pct = 0;
    int words_in = 0;
    int words_out = 0;
    int clipped_words = 0;
    int gain_settings = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    wire in_fire  = in_valid && !in_stall;
    wire out_fire = out_valid && !out_stall;

    windowed_pid_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .error     (error),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .drive     (drive),
        .saturated (saturated)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic drive_word_t compute_drive(input logic signed [ERR_W-1:0] e);
        longint      ev;
        longint      delta;
        longint      avg;
        longint      acc;
        longint      d;
        drive_word_t w;
        ev = e;
        delta = ev - last_error;
        window_total = window_total - window_ring[window_slot] + ev;
        window_ring[window_slot] = ev;
        window_slot = (window_slot == WINDOW - 1) ? 0 : window_slot + 1;
        last_error = ev;
        avg = window_total / WINDOW;
        acc = gain_p * ev + gain_i * avg + gain_d * delta;
        d = acc >>> FRAC_W;
        w.saturated = 1'b0;
        if (d > longint'(DRIVE_MAX))
        begin
            d = longint'(DRIVE_MAX);
            w.saturated = 1'b1;
        end
        else if (d < longint'(DRIVE_MIN))
        begin
            d = longint'(DRIVE_MIN);
            w.saturated = 1'b1;
        end
        w.drive = d[DRIVE_W-1:0];
        return w;
    endfunction

    function automatic logic signed [ERR_W-1:0] random_error();
        logic signed [ERR_W-1:0] e;
        case ($urandom_range(7))
            0, 1: e = ERR_W'($urandom());
            2:
            begin
                case ($urandom_range(3))
                    0: e = {1'b0, {(ERR_W-1){1'b1}}};
                    1: e = {1'b1, {(ERR_W-1){1'b0}}};
                    2: e = '0;
                    default: e = '1;
                endcase
            end
            3: e = ERR_W'(int'($urandom_range(65535)) - 32768);
            default: e = ERR_W'(int'($urandom_range(8191)) - 4096);
        endcase
        return e;
    endfunction

    function automatic logic [GAIN_W-1:0] random_gain();
        logic [GAIN_W-1:0] g;
        case ($urandom_range(5))
            0: g = 16'h7FFF;
            1: g = 16'h8000;
            2: g = '0;
            3: g = GAIN_W'(int'($urandom_range(1023)) - 512);
            default: g = GAIN_W'($urandom());
        endcase
        return g;
    endfunction

    // Each write raises the enable and then lowers it, so the enable is never lowered and raised in one step.
    task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        logic signed [GAIN_W-1:0] sval;
        sval = val;
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_KP: gain_p = sval;
            CFG_KI: gain_i = sval;
            CFG_KD: gain_d = sval;
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_gains(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                             input logic [GAIN_W-1:0] d);
        write_gain(CFG_KP, p);
        write_gain(CFG_KI, i);
        write_gain(CFG_KD, d);
        gain_settings++;
    endtask

    task automatic wait_drained();
        while (error_q.size() != 0 || in_valid || drive_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            error    <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                drive_q.push_back(compute_drive(error));
                words_in++;
            end
            if (!in_valid || !in_stall)
            begin
                if (error_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    in_valid <= 1'b1;
                    error    <= error_q.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_fire)
            begin
                if (drive_q.size() == 0)
                begin
                    $display("%0t: drive word with none expected: drive %0d saturated %0b",
                             $time, drive, saturated);
                    mismatches++;
                end
                else
                begin
                    drive_word_t w;
                    w = drive_q.pop_front();
                    if (drive !== w.drive)
                    begin
                        $display("%0t: drive expected %0d actual %0d", $time, w.drive, drive);
                        mismatches++;
                    end
                    if (saturated !== w.saturated)
                    begin
                        $display("%0t: saturated expected %0b actual %0b",
                                 $time, w.saturated, saturated);
                        mismatches++;
                    end
                    if (w.saturated)
                        clipped_words++;
                end
                words_out++;
            end
            out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_fire || out_fire ||
                (error_q.size() == 0 && !in_valid && drive_q.size() == 0))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("** windowed_pid_controller: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 14;
        rcv_idle_pct = 61;

        // Gains still at their reset value of zero.
        error_q.push_back(24'sh7FFFFF);
        error_q.push_back(24'sh800000);
        wait_drained();

        set_gains(16'h7FFF, 16'h7FFF, 16'h7FFF);
        write_gain(CFG_UNUSED, 16'h1234);
        error_q.push_back(24'sh000000);
        error_q.push_back(24'sh000001);
        error_q.push_back(24'shFFFFFF);
        error_q.push_back(24'sh7FFFFF);
        error_q.push_back(24'sh800000);
        error_q.push_back(24'sh7FFFFF);
        error_q.push_back(24'sh000100);
        error_q.push_back(-24'sh000100);
        wait_drained();

        set_gains(16'h8000, 16'h8000, 16'h8000);
        write_gain(CFG_UNUSED, 16'hFFFF);
        error_q.push_back(24'sh800000);
        error_q.push_back(24'sh7FFFFF);
        error_q.push_back(24'sh800000);
        error_q.push_back(24'sh003039);
        error_q.push_back(24'shFFFFFF);
        error_q.push_back(24'sh000000);
        wait_drained();

        set_gains(16'h0100, 16'h0000, 16'h0000);
        for (int k = 0; k < 6; k++)
            error_q.push_back(24'sh000A00);
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct = 14;
                    rcv_idle_pct = 61;
                end
                1:
                begin
                    src_idle_pct = 61;
                    rcv_idle_pct = 14;
                end
                default:
                begin
                    src_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            for (int chunk = 0; chunk < 3; chunk++)
            begin
                set_gains(random_gain(), random_gain(), random_gain());
                if ($urandom_range(1) == 1)
                    write_gain(CFG_UNUSED, GAIN_W'($urandom()));
                for (int k = 0; k < 110; k++)
                    error_q.push_back(random_error());
                wait_drained();
            end
        end

        repeat (20) @(posedge clk);
        if (drive_q.size() != 0)
        begin
            $display("%0t: %0d drive words never arrived", $time, drive_q.size());
            mismatches++;
        end
        $display("Ran %0d error words through %0d gain settings, %0d drive words checked.",
                 words_in, gain_settings, words_out);
        $display("%0d of those words were clipped; %0d mismatches.", clipped_words, mismatches);
        if (mismatches == 0)
            $display("** windowed_pid_controller: PASSED **");
        else
            $display("** windowed_pid_controller: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/wpid_pkg.sv
hdl/wpid_window.sv
hdl/windowed_pid_controller.sv
dv/tb_top.sv
